FILE: sv/ttb_pkg.sv
// Package for the triangle tangent basis block.
// Holds default widths, result format constants and sequencer term codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

  localparam int COORD_WIDTH_DEF = 16;   // vertex field width
  localparam int RES_WIDTH       = 32;   // result component width
  localparam int OUT_FRAC        = 16;   // fraction bits of the result

  localparam logic [RES_WIDTH-1:0] RES_MAX = {1'b0, {(RES_WIDTH-1){1'b1}}};
  localparam logic [RES_WIDTH-1:0] RES_MIN = {1'b1, {(RES_WIDTH-1){1'b0}}};

  // Sequencer terms: determinant first, then tangent and bitangent per axis.
  localparam logic [2:0] TERM_DET = 3'd0;
  localparam logic [2:0] TERM_TX  = 3'd1;
  localparam logic [2:0] TERM_BX  = 3'd2;
  localparam logic [2:0] TERM_TY  = 3'd3;
  localparam logic [2:0] TERM_BY  = 3'd4;
  localparam logic [2:0] TERM_TZ  = 3'd5;
  localparam logic [2:0] TERM_BZ  = 3'd6;

  localparam int NUM_COMP = 6;           // tangent xyz plus bitangent xyz

endpackage

`default_nettype wire

FILE: sv/ttb_if.sv
// Handshake channels of the triangle tangent basis block.
// ttb_vtx_if carries one vertex, ttb_res_if one tangent/bitangent result.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ttb_vtx_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] tex_u;
  logic signed [COORD_WIDTH-1:0] tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_res_if import ttb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RES_WIDTH-1:0] tan_x;
  logic signed [RES_WIDTH-1:0] tan_y;
  logic signed [RES_WIDTH-1:0] tan_z;
  logic signed [RES_WIDTH-1:0] bitan_x;
  logic signed [RES_WIDTH-1:0] bitan_y;
  logic signed [RES_WIDTH-1:0] bitan_z;
  logic                        degenerate;

  modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                  degenerate, input ready);
  modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                  degenerate, output ready);
endinterface

`default_nettype wire

FILE: sv/triangle_tangent_basis_top.sv
// Top level of the triangle tangent basis block.
// Depends on ttb_pkg and the channel interfaces in ttb_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Vertices stream in on vtx_i and are grouped three at a time into
// triangles; the third corner of each triangle yields one item on res_o
// with tangent and bitangent in signed Q16.16, each component
// (numerator << 16) / det truncated toward zero and saturated to 32 bits.
// A zero UV determinant gives zero vectors with degenerate set. The first
// and second corners are only held. The third corner starts a sequencer
// around one signed (COORD_WIDTH+1)-bit multiplier and one restoring
// divider that retires one quotient bit per cycle. The determinant takes
// three multiply/subtract steps and a zero check; each of the six components
// takes the same three steps, a divider setup, one step per quotient bit
// (none on overflow) and a saturation step. vtx_i stays not ready from a
// third corner until the result is loaded into the output register, which
// waits for res_o to take the previous result. The output register holds
// a finished item while the next triangle's first corners are taken.

module triangle_tangent_basis_top import ttb_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ttb_vtx_if.sink    vtx_i,
  ttb_res_if.source  res_o
);

  localparam int DW = COORD_WIDTH + 1;       // corner difference width
  localparam int AW = 2 * DW;                // product / numerator width
  localparam int MW = AW - 1;                // magnitude width
  localparam int CW = $clog2(RES_WIDTH);     // quotient bit counter width

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL0 = 8'b0000_0010,
    ST_MUL1 = 8'b0000_0100,
    ST_SUB  = 8'b0000_1000,
    ST_DIVI = 8'b0001_0000,
    ST_DIVS = 8'b0010_0000,
    ST_DIVF = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic signed [COORD_WIDTH-1:0] tu;
    logic signed [COORD_WIDTH-1:0] tv;
  } corner_t;

  state_e state_q, state_d;

  // Held corners and count
  corner_t    held_q [2];
  logic [1:0] corner_cnt_q;

  // Edge and UV deltas of the open triangle
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  // Multiply / accumulate datapath
  logic [2:0]           term_q;
  logic signed [AW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;

  // Divider
  logic [MW-1:0]        dmag_q;
  logic                 dsign_q;
  logic [MW-1:0]        rem_q;
  logic [RES_WIDTH-1:0] nlo_q;
  logic [RES_WIDTH-1:0] quo_q;
  logic [CW-1:0]        bit_cnt_q;
  logic                 neg_q;
  logic                 ovf_q;

  // Results
  logic [RES_WIDTH-1:0] res_q [NUM_COMP];
  logic                 degen_q;

  // Output register
  logic                 out_valid_q;
  logic [RES_WIDTH-1:0] out_q [NUM_COMP];
  logic                 out_degen_q;

  logic vtx_fire;
  logic out_free;

  assign vtx_i.ready = (state_q == ST_IDLE);
  assign vtx_fire    = vtx_i.valid && vtx_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  // Incoming corner, packed
  corner_t cur;
  assign cur = '{px: vtx_i.pos_x, py: vtx_i.pos_y, pz: vtx_i.pos_z,
                 tu: vtx_i.tex_u, tv: vtx_i.tex_v};

  function automatic logic signed [DW-1:0] sdiff(logic signed [COORD_WIDTH-1:0] a,
                                                 logic signed [COORD_WIDTH-1:0] b);
    logic signed [DW-1:0] ae, be;
    ae = {a[COORD_WIDTH-1], a};
    be = {b[COORD_WIDTH-1], b};
    return ae - be;
  endfunction

  // Operand select: det = du1*dv2 - du2*dv1, T = dv2*e1 - dv1*e2,
  // B = du1*e2 - du2*e1.
  logic                 phase;
  logic signed [DW-1:0] e1_sel, e2_sel, op_a, op_b;
  logic signed [AW-1:0] prod_d;

  assign phase = (state_q == ST_MUL1);

  always_comb begin
    if (term_q inside {TERM_TX, TERM_BX}) begin
      e1_sel = e1_q[0];
      e2_sel = e2_q[0];
    end else if (term_q inside {TERM_TY, TERM_BY}) begin
      e1_sel = e1_q[1];
      e2_sel = e2_q[1];
    end else begin
      e1_sel = e1_q[2];
      e2_sel = e2_q[2];
    end
    if (term_q == TERM_DET) begin
      op_a = phase ? du2_q : du1_q;
      op_b = phase ? dv1_q : dv2_q;
    end else if (term_q[0]) begin
      op_a = phase ? dv1_q : dv2_q;
      op_b = phase ? e2_sel : e1_sel;
    end else begin
      op_a = phase ? du2_q : du1_q;
      op_b = phase ? e1_sel : e2_sel;
    end
  end

  assign prod_d = op_a * op_b;

  // Magnitude of the accumulated term
  logic [MW-1:0] acc_mag;
  logic [AW-1:0] acc_neg;
  assign acc_neg = -acc_q;
  assign acc_mag = acc_q[AW-1] ? acc_neg[MW-1:0] : acc_q[MW-1:0];

  // One restoring step: shift in the next dividend bit, try the subtract
  logic [MW:0] trial;
  logic        trial_ok;
  assign trial    = {rem_q, nlo_q[RES_WIDTH-1]} - {1'b0, dmag_q};
  assign trial_ok = !trial[MW];

  // Saturated, signed component from quotient and sign
  logic [RES_WIDTH-1:0] comp_val;
  always_comb begin
    if (ovf_q || quo_q[RES_WIDTH-1]) begin
      comp_val = neg_q ? RES_MIN : RES_MAX;
    end else begin
      comp_val = neg_q ? -quo_q : quo_q;
    end
  end

  logic [2:0] res_idx;
  assign res_idx = 3'(term_q - 3'd1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (vtx_fire && corner_cnt_q == 2'd2) state_d = ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_SUB;
      ST_SUB:  state_d = ST_DIVI;
      ST_DIVI: begin
        if (term_q == TERM_DET) begin
          state_d = (acc_q == '0) ? ST_DONE : ST_MUL0;
        end else if ((acc_mag >> OUT_FRAC) >= dmag_q) begin
          state_d = ST_DIVF;
        end else begin
          state_d = ST_DIVS;
        end
      end
      ST_DIVS: if (bit_cnt_q == CW'(RES_WIDTH - 1)) state_d = ST_DIVF;
      ST_DIVF: state_d = (term_q == TERM_BZ) ? ST_DONE : ST_MUL0;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      corner_cnt_q <= 2'd0;
      held_q[0]    <= '0;
      held_q[1]    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (vtx_fire) begin
        if (corner_cnt_q == 2'd2) begin
          corner_cnt_q <= 2'd0;
        end else begin
          held_q[corner_cnt_q[0]] <= cur;
          corner_cnt_q            <= corner_cnt_q + 2'd1;
        end
      end
      // Drop the output item once taken; load a new one at the end of a triangle
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (vtx_fire && corner_cnt_q == 2'd2) begin
          // Third corner: form edges and UV deltas
          e1_q[0] <= sdiff(held_q[1].px, held_q[0].px);
          e1_q[1] <= sdiff(held_q[1].py, held_q[0].py);
          e1_q[2] <= sdiff(held_q[1].pz, held_q[0].pz);
          e2_q[0] <= sdiff(cur.px, held_q[0].px);
          e2_q[1] <= sdiff(cur.py, held_q[0].py);
          e2_q[2] <= sdiff(cur.pz, held_q[0].pz);
          du1_q   <= sdiff(held_q[1].tu, held_q[0].tu);
          dv1_q   <= sdiff(held_q[1].tv, held_q[0].tv);
          du2_q   <= sdiff(cur.tu, held_q[0].tu);
          dv2_q   <= sdiff(cur.tv, held_q[0].tv);
          term_q  <= TERM_DET;
          degen_q <= 1'b0;
        end
      end
      ST_MUL0: prod_q <= prod_d;
      ST_MUL1: begin
        acc_q  <= prod_q;
        prod_q <= prod_d;
      end
      ST_SUB:  acc_q <= acc_q - prod_q;
      ST_DIVI: begin
        if (term_q == TERM_DET) begin
          if (acc_q == '0) begin
            // Degenerate UV mapping: zero vectors
            for (int i = 0; i < NUM_COMP; i++) res_q[i] <= '0;
            degen_q <= 1'b1;
          end else begin
            dmag_q  <= acc_mag;
            dsign_q <= acc_q[AW-1];
            term_q  <= TERM_TX;
          end
        end else begin
          neg_q     <= acc_q[AW-1] ^ dsign_q;
          ovf_q     <= ((acc_mag >> OUT_FRAC) >= dmag_q);
          rem_q     <= acc_mag >> OUT_FRAC;
          nlo_q     <= {acc_mag[OUT_FRAC-1:0], {(RES_WIDTH-OUT_FRAC){1'b0}}};
          quo_q     <= '0;
          bit_cnt_q <= '0;
        end
      end
      ST_DIVS: begin
        rem_q     <= trial_ok ? trial[MW-1:0] : {rem_q[MW-2:0], nlo_q[RES_WIDTH-1]};
        nlo_q     <= {nlo_q[RES_WIDTH-2:0], 1'b0};
        quo_q     <= {quo_q[RES_WIDTH-2:0], trial_ok};
        bit_cnt_q <= bit_cnt_q + CW'(1);
      end
      ST_DIVF: begin
        res_q[res_idx] <= comp_val;
        term_q         <= term_q + 3'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          for (int i = 0; i < NUM_COMP; i++) out_q[i] <= res_q[i];
          out_degen_q <= degen_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.tan_x      = out_q[0];
  assign res_o.bitan_x    = out_q[1];
  assign res_o.tan_y      = out_q[2];
  assign res_o.bitan_y    = out_q[3];
  assign res_o.tan_z      = out_q[4];
  assign res_o.bitan_z    = out_q[5];
  assign res_o.degenerate = out_degen_q;

endmodule

`default_nettype wire

FILE: tb/triangle_tangent_basis_top_test.sv
// Testbench for triangle_tangent_basis_top: streams vertices and checks each
// tangent/bitangent item against a predictor held inside this module.
// Depends on ttb_pkg, the channels in ttb_if.sv and the top level.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_basis_top_test;
  import ttb_pkg::*;

  localparam int     CW              = COORD_WIDTH_DEF;
  localparam int     CYCLE_LIMIT     = 1_000_000;
  localparam int     HOLD_OFF_CYCLES = 2000;
  // Outlasts the time that a third corner keeps the block busy.
  localparam int     DRAIN_CYCLES    = 300;
  localparam int     MAX_PRINTED     = 100;
  localparam longint Q_HI            = 64'sd2147483647;
  localparam longint Q_LO            = -Q_HI - 1;

  typedef logic signed [CW-1:0] coord_t;

  // One vertex: position xyz and texture coordinate uv.
  typedef struct {
    coord_t pos[3];
    coord_t u;
    coord_t v;
  } vertex_t;

  // One result item: tangent, bitangent and the degenerate flag.
  typedef struct {
    logic [RES_WIDTH-1:0] tan[3];
    logic [RES_WIDTH-1:0] bitan[3];
    logic                 degenerate;
  } basis_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttb_vtx_if #(.COORD_WIDTH(CW)) vtx_if ();
  ttb_res_if                     res_if ();

  triangle_tangent_basis_top #(.COORD_WIDTH(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_if),
    .res_o  (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: the open triangle's first corners and how many are held.
  vertex_t corner_hold[2];
  int      corners_held = 0;
  // Tangent bases still owed by the block, oldest first.
  basis_t  basis_due[$];

  int      mismatches   = 0;
  int      results_seen = 0;
  int      cycle_count  = 0;
  bit      idling_on    = 1'b0;
  // The test sequence raises hold_off_asked; the result side serves it.
  int      hold_off_asked  = 0;
  int      hold_off_served = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // (num << 16) / det, truncated toward zero, clamped to the 32-bit range.
  function automatic logic [RES_WIDTH-1:0] q16_ratio(input longint num, input longint det);
    longint q;
    q = (num <<< OUT_FRAC) / det;
    if (q > Q_HI) return RES_MAX;
    if (q < Q_LO) return RES_MIN;
    return q[RES_WIDTH-1:0];
  endfunction

  // Edges and UV deltas taken from corner a; all products fit in 64 bits.
  function automatic basis_t tangent_basis_of(input vertex_t a, input vertex_t b,
                                              input vertex_t c);
    longint e1, e2, du1, dv1, du2, dv2, det;
    basis_t r;
    int     k;
    du1 = longint'(b.u) - longint'(a.u);
    dv1 = longint'(b.v) - longint'(a.v);
    du2 = longint'(c.u) - longint'(a.u);
    dv2 = longint'(c.v) - longint'(a.v);
    det = du1 * dv2 - du2 * dv1;
    r.degenerate = (det == 0);
    for (k = 0; k < 3; k++) begin
      e1 = longint'(b.pos[k]) - longint'(a.pos[k]);
      e2 = longint'(c.pos[k]) - longint'(a.pos[k]);
      if (det == 0) begin
        r.tan[k]   = '0;
        r.bitan[k] = '0;
      end else begin
        r.tan[k]   = q16_ratio(dv2 * e1 - dv1 * e2, det);
        r.bitan[k] = q16_ratio(du1 * e2 - du2 * e1, det);
      end
    end
    return r;
  endfunction

  // Hold the first two corners; the third closes the triangle and owes a result.
  function automatic void fold_corner(input vertex_t v);
    if (corners_held < 2) begin
      corner_hold[corners_held] = v;
      corners_held++;
    end else begin
      basis_due.push_back(tangent_basis_of(corner_hold[0], corner_hold[1], v));
      corners_held = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Vertex side
  // ---------------------------------------------------------------------------

  function automatic vertex_t vtx(input int px, input int py, input int pz,
                                  input int u, input int v);
    vertex_t r;
    r.pos[0] = coord_t'(px);
    r.pos[1] = coord_t'(py);
    r.pos[2] = coord_t'(pz);
    r.u      = coord_t'(u);
    r.v      = coord_t'(v);
    return r;
  endfunction

  // Entered and left at a falling edge. Insert a random gap when idling is on,
  // hold the item until the block takes it, then feed the predictor.
  task automatic send_vertex(input vertex_t v);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      vtx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    vtx_if.valid <= 1'b1;
    vtx_if.pos_x <= v.pos[0];
    vtx_if.pos_y <= v.pos[1];
    vtx_if.pos_z <= v.pos[2];
    vtx_if.tex_u <= v.u;
    vtx_if.tex_v <= v.v;
    do @(posedge clk_i); while (vtx_if.ready !== 1'b1);
    fold_corner(v);
    @(negedge clk_i);
  endtask

  // Drop valid once a stream ends so no stale item is offered.
  task automatic idle_input();
    vtx_if.valid <= 1'b0;
  endtask

  function automatic coord_t jitter(input int base, input int spread);
    return coord_t'(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // One triangle in one of several shapes: raw noise, mesh-like small
  // triangles, collinear UVs (zero determinant), tiny determinants that push
  // the quotients into saturation, and flat positions (zero numerators).
  task automatic send_random_triangle();
    vertex_t corner[3];
    int      pick, i, k, du, dv, base_u, base_v;
    int      base_pos[3];
    pick = $urandom_range(0, 99);
    for (i = 0; i < 3; i++) begin
      for (k = 0; k < 3; k++) corner[i].pos[k] = coord_t'($urandom);
      corner[i].u = coord_t'($urandom);
      corner[i].v = coord_t'($urandom);
    end
    base_u = $urandom_range(0, 48000) - 24000;
    base_v = $urandom_range(0, 48000) - 24000;
    if (pick >= 25 && pick < 60) begin
      for (k = 0; k < 3; k++) base_pos[k] = $urandom_range(0, 48000) - 24000;
      for (i = 0; i < 3; i++) begin
        for (k = 0; k < 3; k++) corner[i].pos[k] = jitter(base_pos[k], 2048);
        corner[i].u = jitter(base_u, 512);
        corner[i].v = jitter(base_v, 512);
      end
    end else if (pick >= 60 && pick < 75) begin
      du = $urandom_range(0, 2000) - 1000;
      dv = $urandom_range(0, 2000) - 1000;
      k  = $urandom_range(0, 6) - 3;
      corner[0].u = coord_t'(base_u);
      corner[0].v = coord_t'(base_v);
      corner[1].u = coord_t'(base_u + du);
      corner[1].v = coord_t'(base_v + dv);
      corner[2].u = coord_t'(base_u + k * du);
      corner[2].v = coord_t'(base_v + k * dv);
    end else if (pick >= 75 && pick < 90) begin
      for (i = 0; i < 3; i++) begin
        corner[i].u = jitter(base_u, (i == 0) ? 0 : 1);
        corner[i].v = jitter(base_v, (i == 0) ? 0 : 1);
      end
    end else if (pick >= 90) begin
      for (i = 1; i < 3; i++) corner[i].pos = corner[0].pos;
    end
    for (i = 0; i < 3; i++) send_vertex(corner[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready changes only at falling edges. A hold-off request wins over
  // random stall bursts; with idling off, no new stall bursts start.
  initial begin : result_ready_drive
    int burst, hold_left;
    burst     = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_asked != hold_off_served) begin
        res_if.ready <= 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        hold_off_served++;
      end else if (burst > 0) begin
        res_if.ready <= 1'b0;
        burst--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        burst = $urandom_range(0, 11);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch: result %0d %s got %0d expected %0d",
               results_seen, field, got, want);
  endtask

  // Compare one taken result, field by field, with the oldest owed basis.
  task automatic check_result();
    basis_t               want;
    logic [RES_WIDTH-1:0] got_tan[3];
    logic [RES_WIDTH-1:0] got_bitan[3];
    int                   k;
    results_seen++;
    if (basis_due.size() == 0) begin
      report_mismatch("unexpected result, count", results_seen, 0);
      return;
    end
    want      = basis_due.pop_front();
    got_tan   = '{res_if.tan_x, res_if.tan_y, res_if.tan_z};
    got_bitan = '{res_if.bitan_x, res_if.bitan_y, res_if.bitan_z};
    for (k = 0; k < 3; k++) begin
      if (got_tan[k] !== want.tan[k])
        report_mismatch($sformatf("tan[%0d]", k),
                        longint'($signed(got_tan[k])), longint'($signed(want.tan[k])));
      if (got_bitan[k] !== want.bitan[k])
        report_mismatch($sformatf("bitan[%0d]", k),
                        longint'($signed(got_bitan[k])), longint'($signed(want.bitan[k])));
    end
    if (res_if.degenerate !== want.degenerate)
      report_mismatch("degenerate", longint'(res_if.degenerate), longint'(want.degenerate));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      check_result();
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked triangles: field extremes, a zero determinant, saturation
  // both ways, zero numerators over a negative determinant, the exact
  // -2^31 and +2^31 boundaries, a unit triangle and truncation of negatives.
  task automatic test_corner_cases();
    idling_on = 1'b0;
    send_vertex(vtx(-32768, -32768, -32768, -32768, -32768));
    send_vertex(vtx( 32767,  32767,  32767,  32767,  32767));
    send_vertex(vtx( 32767, -32768,      0,  32767, -32768));

    send_vertex(vtx(   0,    0, 0, 1000, -2000));
    send_vertex(vtx(4096,    0, 0, 1000, -2000));
    send_vertex(vtx(   0, 4096, 0, 1000, -2000));

    send_vertex(vtx(-32768,  32767,   100, 0, 0));
    send_vertex(vtx( 32767, -32768,  -200, 1, 0));
    send_vertex(vtx( 12345, -32768, 32767, 0, 1));

    send_vertex(vtx(5, 5, 5, 0, 0));
    send_vertex(vtx(5, 5, 5, 0, 1));
    send_vertex(vtx(5, 5, 5, 1, 0));

    send_vertex(vtx(     0,    -1,     0, 0, 0));
    send_vertex(vtx(-32768, 32767, 32767, 1, 0));
    send_vertex(vtx(     0,     0,     0, 0, 1));

    send_vertex(vtx(   0,    0, 0,    0,    0));
    send_vertex(vtx(4096,    0, 0, 4096,    0));
    send_vertex(vtx(   0, 4096, 0,    0, 4096));

    send_vertex(vtx(0,  0,  0, 0, 0));
    send_vertex(vtx(1, -1,  7, 3, 0));
    send_vertex(vtx(2,  5, -3, 0, 3));
    idle_input();
  endtask

  // Random triangles with idle bursts on both channels.
  task automatic test_random_traffic();
    idling_on = 1'b1;
    repeat (400) send_random_triangle();
    idle_input();
  endtask

  // Stall the result side for a long stretch while vertices keep coming,
  // so the output register fills and the block stops taking corners.
  task automatic test_output_backpressure();
    idling_on = 1'b0;
    hold_off_asked++;
    repeat (20) send_random_triangle();
    idle_input();
  endtask

  // Back-to-back vertices with no idling on either side to close the run.
  task automatic test_streaming();
    idling_on = 1'b0;
    repeat (190) send_random_triangle();
    idle_input();
  endtask

  initial begin : run_tests
    rst_ni        = 1'b0;
    vtx_if.valid <= 1'b0;
    vtx_if.pos_x <= '0;
    vtx_if.pos_y <= '0;
    vtx_if.pos_z <= '0;
    vtx_if.tex_u <= '0;
    vtx_if.tex_v <= '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_corner_cases();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();

    // Wait out owed results, then give stray items time to show up.
    while (basis_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // End a run that hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
